// File: rtl/mgs_pkg.sv
// Shared types for the merge sorter: the data held in one sorting cell and
// the per-cycle controls that the top level sends to every cell.
// No dependencies.
package mgs_pkg;

    localparam int VALUE_W = 32;

    typedef logic signed [VALUE_W-1:0] t_value;

    // Contents of one cell; the value is meaningful only while valid is set.
    typedef struct packed {
        logic   valid;
        t_value value;
    } t_cell_state;

    // Controls sent to every cell in the same cycle.
    typedef struct packed {
        logic   insert;
        logic   shift;
        t_value new_value;
    } t_cell_ctrl;

endpackage

// File: rtl/mgs_cell.sv
// One cell of the sorting chain: holds one element and hands it right on an
// insert or left on a drain shift.
// Depends on mgs_pkg.
module mgs_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mgs_pkg::t_cell_ctrl  i_ctrl,
    input  mgs_pkg::t_cell_state i_left,
    input  logic                i_left_open,
    input  mgs_pkg::t_cell_state i_right,
    output mgs_pkg::t_cell_state o_state,
    output logic                o_open
);
    import mgs_pkg::*;

    logic   r_valid;
    t_value r_value;
    logic   n_valid;
    t_value n_value;

    // A cell opens for the new element when it is empty or holds a strictly
    // greater value; equal values stay ahead, which keeps the order stable.
    assign o_open = !r_valid || (r_value > i_ctrl.new_value);

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_ctrl.shift) begin
            n_valid = i_right.valid;
            n_value = i_right.value;
        end else if (i_ctrl.insert && o_open) begin
            if (i_left_open) begin
                n_valid = i_left.valid;
                n_value = i_left.value;
            end else begin
                n_valid = 1'b1;
                n_value = i_ctrl.new_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_state.valid = r_valid;
    assign o_state.value = r_value;

endmodule

// File: rtl/merge_sorter_core.sv
// Sorting block: a chain of insertion cells that keeps the set in ascending
// order as elements arrive. Depends on mgs_pkg and mgs_cell.
// The first sorted element shows in the cycle after the final request.
// Throughput: one element per cycle in while loading, then one per cycle out
// while the receiver is ready, set by the single-step insertion and the left shift.
// Reset (synchronous, active low) empties every cell and returns to loading.
module merge_sorter_core #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] value
    input  logic        i_s_tlast,   // final_item
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] sorted_value
    output logic        o_m_tlast    // final_result
);
    import mgs_pkg::*;

    // The block loads a set, then drains it. While draining no request is
    // taken on the input side; cell 0 serves as the output register.
    logic r_drain;
    logic n_drain;

    t_cell_state w_state [MAX_ELEMENTS];
    logic        w_open  [MAX_ELEMENTS];
    t_cell_ctrl  w_ctrl;

    logic in_accept;
    logic out_accept;
    logic full;

    // The set is full when the last cell holds an element; further
    // elements are dropped, but their final flag still starts the drain.
    assign full       = w_state[MAX_ELEMENTS-1].valid;
    assign o_s_tready = !r_drain;
    assign in_accept  = i_s_tvalid && o_s_tready;

    assign o_m_tvalid = r_drain && w_state[0].valid;
    assign o_m_tdata  = w_state[0].value;
    assign o_m_tlast  = !w_state[1].valid;
    assign out_accept = o_m_tvalid && i_m_tready;

    assign w_ctrl.insert    = in_accept && !full;
    assign w_ctrl.shift     = out_accept;
    assign w_ctrl.new_value = i_s_tdata;

    always_comb begin
        n_drain = r_drain;
        if (in_accept && i_s_tlast) begin
            n_drain = 1'b1;
        end else if (out_accept && o_m_tlast) begin
            n_drain = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain <= 1'b0;
        end else begin
            r_drain <= n_drain;
        end
    end

    // Each cell sees its left neighbor for inserts and its right neighbor
    // for drain shifts. The ends of the chain see an empty, closed cell.
    for (genvar g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
        t_cell_state left_state;
        logic        left_open;
        t_cell_state right_state;

        if (g == 0) begin : g_head
            assign left_state = '0;
            assign left_open  = 1'b0;
        end else begin : g_body
            assign left_state = w_state[g-1];
            assign left_open  = w_open[g-1];
        end

        if (g == MAX_ELEMENTS-1) begin : g_tail
            assign right_state = '0;
        end else begin : g_inner
            assign right_state = w_state[g+1];
        end

        mgs_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_left      (left_state),
            .i_left_open (left_open),
            .i_right     (right_state),
            .o_state     (w_state[g]),
            .o_open      (w_open[g])
        );
    end

endmodule

// File: rtl/mgs_checker.sv
// Port-level checks for merge_sorter_core, bound to the top level.
// Depends on merge_sorter_core's port list only.
module mgs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [31:0] i_s_tdata,
    input logic        i_s_tlast,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic        o_m_tlast
);

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
        && $stable(o_m_tlast))
        else $error("stalled result changed");

    // No request is taken while a set is being drained.
    a_no_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready)
        else $error("input ready while draining");

    // The final request of a set starts the output at the next cycle.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tlast |=> o_m_tvalid)
        else $error("drain did not start");

    // Within a set, results continue and never decrease.
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast |=> o_m_tvalid
        && !($signed(o_m_tdata) < $signed($past(o_m_tdata))))
        else $error("results out of order");

endmodule

bind merge_sorter_core mgs_checker u_mgs_checker (.*);
